// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define SSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ssf check failed");

// checked on every edge, reset included
`define SSF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ssf check failed");

`endif

// ===== rtl/core/ssf_pkg.sv =====
package ssf_pkg;

  localparam int SW   = 32;        // sample width
  localparam int FRAC = 30;        // geometry fraction bits
  localparam int QW   = FRAC + 1;  // normalized magnitude bits
  localparam int RW   = 17;        // radius register width
  localparam int R30W = RW + 14;   // radius in q.30
  localparam int AW   = 4;         // apb address width
  localparam int DW   = 32;        // apb data width

  localparam logic [AW-3:0] REG_LOWER  = 2'd0;
  localparam logic [AW-3:0] REG_UPPER  = 2'd1;
  localparam logic [AW-3:0] REG_RADIUS = 2'd2;

  localparam logic [SW-1:0] LOWER_RST  = -SW'(65536);
  localparam logic [SW-1:0] UPPER_RST  = SW'(65536);
  localparam logic [RW-1:0] RADIUS_RST = RW'(6554);

  localparam logic [28:0] TAN_PI8 = 29'd444758426;
  localparam logic [29:0] COS_PI4 = 30'd759250125;

  localparam logic [2:0] REGION_LINEAR     = 3'd0;
  localparam logic [2:0] REGION_UPPER_FLAT = 3'd1;
  localparam logic [2:0] REGION_LOWER_FLAT = 3'd2;
  localparam logic [2:0] REGION_UPPER_ARC  = 3'd3;
  localparam logic [2:0] REGION_LOWER_ARC  = 3'd4;

  localparam logic [1:0] CLS_LINEAR = 2'd0;
  localparam logic [1:0] CLS_FLAT   = 2'd1;
  localparam logic [1:0] CLS_ARC    = 2'd2;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic                 neg;
    logic                 bad;
    logic                 far;
    logic [1:0]           cls;
  } meta_t;

endpackage

// ===== rtl/core/soft_saturation_fillet.sv =====
// Soft saturation with circular fillets: one signed Q16.16 sample in, one shaped sample out,
// one item per clock while the output is not stalled. On its way to out_valid_o the normalizing
// divide runs one quotient bit per stage (31 stages) and the fillet square root one result
// bit per stage (32 stages), with a few stages of multiply and rounding around them. A stall
// on the output freezes the whole pipeline; the input is stalled only while a result waits.
// The fillet geometry is derived from the radius register in a free-running side pipeline
// and is used by an item at the region stage, after the divider.
module soft_saturation_fillet (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssf_pkg::AW-1:0]        paddr,
  input  logic [ssf_pkg::DW-1:0]        pwdata,
  output logic [ssf_pkg::DW-1:0]        prdata,
  output logic                          pready,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic signed [ssf_pkg::SW-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ssf_pkg::SW-1:0] shaped_o,
  output logic [2:0]                    region_o,
  output logic                          bad_limits_o
);

  localparam int SW    = ssf_pkg::SW;
  localparam int QW    = ssf_pkg::QW;
  localparam int FRAC  = ssf_pkg::FRAC;
  localparam int R30W  = ssf_pkg::R30W;
  localparam int SQN   = 32;             // root bits
  localparam int SQXW  = 62;             // radicand width
  localparam int SQRW  = 63;             // partial root width
  localparam int MW    = 32;             // |m| width
  localparam int PW    = MW + SW;
  localparam int SCW   = PW - FRAC + 1;
  localparam int TW    = SCW + 2;
  localparam int S_DIV = 1;
  localparam int S_R   = S_DIV + QW;
  localparam int S_M   = S_R + 1;
  localparam int S_Q   = S_M + 1;
  localparam int S_SQ  = S_Q + 1;
  localparam int S_V   = S_SQ + SQN;
  localparam int S_X   = S_V + 1;
  localparam int S_Y   = S_X + 1;
  localparam int NST   = S_Y + 1;

  localparam logic [FRAC:0]    ONE_Q    = {1'b1, {FRAC{1'b0}}};
  localparam logic [FRAC+1:0]  HALF_Q   = {2'b0, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [TW-1:0] SAT_HI = {{(TW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

  // configuration
  logic signed [SW-1:0]       lower_q, upper_q;
  logic [ssf_pkg::RW-1:0]     radius_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= ssf_pkg::LOWER_RST;
      upper_q  <= ssf_pkg::UPPER_RST;
      radius_q <= ssf_pkg::RADIUS_RST;
    end else if (wr_en) begin
      case (paddr[ssf_pkg::AW-1:2])
        ssf_pkg::REG_LOWER:  lower_q  <= pwdata[SW-1:0];
        ssf_pkg::REG_UPPER:  upper_q  <= pwdata[SW-1:0];
        ssf_pkg::REG_RADIUS: radius_q <= pwdata[ssf_pkg::RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ssf_pkg::AW-1:2])
      ssf_pkg::REG_LOWER:  prdata = lower_q;
      ssf_pkg::REG_UPPER:  prdata = upper_q;
      ssf_pkg::REG_RADIUS: prdata = ssf_pkg::DW'(radius_q);
      default:             prdata = '0;
    endcase
  end

  // fillet geometry, free-running registers that follow a radius write
  logic [R30W-1:0]   r30_w;
  logic [R30W+28:0]  tp_q;
  logic [R30W-1:0]   bl_q, cl_q;
  logic [R30W+29:0]  cp_q;
  logic [2*R30W-1:0] rr_q;
  logic [31:0]       bstop_q, bstart_q;
  logic [R30W+29:0]  tp_rnd;
  logic [R30W+30:0]  cp_rnd;

  assign r30_w  = {radius_q, 14'b0};
  assign tp_rnd = {1'b0, tp_q} + (R30W+30)'(HALF_Q);
  assign cp_rnd = {1'b0, cp_q} + (R30W+31)'(HALF_Q);

  always_ff @(posedge clk_i) begin
    tp_q     <= (R30W+29)'(r30_w) * (R30W+29)'(ssf_pkg::TAN_PI8);
    rr_q     <= (2*R30W)'(r30_w) * (2*R30W)'(r30_w);
    bl_q     <= tp_rnd[FRAC +: R30W];
    cp_q     <= (R30W+30)'(bl_q) * (R30W+30)'(ssf_pkg::COS_PI4);
    cl_q     <= cp_rnd[FRAC +: R30W];
    bstop_q  <= 32'(ONE_Q) + 32'(bl_q);
    bstart_q <= 32'(ONE_Q) - 32'(cl_q);
  end

  // limits read by several stages; to be changed only while the pipeline is empty, which the block does not enforce
  logic signed [SW:0]   diff_w, sum_w;
  logic [SW-1:0]        rng_w;
  logic                 bad_w;

  assign diff_w = {upper_q[SW-1], upper_q} - {lower_q[SW-1], lower_q};
  assign sum_w  = {upper_q[SW-1], upper_q} + {lower_q[SW-1], lower_q};
  assign rng_w  = diff_w[SW-1:0];
  assign bad_w  = (upper_q <= lower_q);

  // pipeline control
  logic              adv;
  logic              out_valid_q;
  logic [NST-1:0]    vld_q;
  ssf_pkg::meta_t    meta_q [NST];

  assign adv            = !out_valid_q || !out_stall_i;
  assign sample_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NST-2:0], sample_valid_i};
      out_valid_q <= vld_q[NST-1];
    end
  end

  // stage 0: offset from the midpoint, doubled
  logic signed [SW+1:0] d2_w;
  logic [SW+1:0]        ad_w, ad_q;
  ssf_pkg::meta_t       m0_w;

  always_comb begin
    d2_w     = {sample_i[SW-1], sample_i, 1'b0} - {sum_w[SW], sum_w};
    ad_w     = d2_w[SW+1] ? -d2_w : d2_w;
    m0_w.x   = sample_i;
    m0_w.neg = d2_w[SW+1];
    m0_w.bad = bad_w;
    m0_w.far = (ad_w >= {1'b0, rng_w, 1'b0});
    m0_w.cls = ssf_pkg::CLS_LINEAR;
  end

  // divider: one quotient bit per stage
  logic [SW-1:0] drem_d [QW];
  logic [SW-1:0] drem_q [QW];
  logic [QW-1:0] dq_d   [QW];
  logic [QW-1:0] dq_q   [QW];

  always_comb begin
    logic [SW+1:0] a0;
    logic [SW:0]   r2;
    logic          ge;
    a0        = ad_q - (SW+2)'(rng_w);
    ge        = (ad_q >= (SW+2)'(rng_w));
    drem_d[0] = ge ? a0[SW-1:0] : ad_q[SW-1:0];
    dq_d[0]   = QW'(ge);
    for (int k = 1; k < QW; k++) begin
      r2        = {drem_q[k-1], 1'b0};
      ge        = (r2 >= {1'b0, rng_w});
      drem_d[k] = ge ? SW'(r2 - {1'b0, rng_w}) : r2[SW-1:0];
      dq_d[k]   = {dq_q[k-1][QW-2:0], ge};
    end
  end

  // region class and distance into the arc
  logic [31:0]     auc_w, tfull_w;
  logic [1:0]      cls_w;
  ssf_pkg::meta_t  mr_w;
  logic [30:0]     t_q;
  logic [SQXW-1:0] t2_q, sr_q;

  always_comb begin
    auc_w   = meta_q[S_R-1].far ? bstop_q : 32'(dq_q[QW-1]);
    tfull_w = bstop_q - auc_w;
    if (auc_w >= bstop_q) begin
      cls_w = ssf_pkg::CLS_FLAT;
    end else if (auc_w <= bstart_q) begin
      cls_w = ssf_pkg::CLS_LINEAR;
    end else begin
      cls_w = ssf_pkg::CLS_ARC;
    end
    mr_w     = meta_q[S_R-1];
    mr_w.cls = cls_w;
  end

  // square root: one result bit per stage
  logic [SQXW-1:0] sx_d [SQN];
  logic [SQXW-1:0] sx_q [SQN];
  logic [SQRW-1:0] sr_d [SQN];
  logic [SQRW-1:0] srt_q [SQN];

  always_comb begin
    logic [SQXW-1:0] xin;
    logic [SQRW-1:0] rin, bitv, tsum;
    for (int k = 0; k < SQN; k++) begin
      xin  = (k == 0) ? sr_q : sx_q[(k == 0) ? 0 : k-1];
      rin  = (k == 0) ? '0 : srt_q[(k == 0) ? 0 : k-1];
      bitv = SQRW'(1) << (SQXW - 2*k);
      tsum = rin + bitv;
      if ({1'b0, xin} >= tsum) begin
        sx_d[k] = xin - tsum[SQXW-1:0];
        sr_d[k] = (rin >> 1) + bitv;
      end else begin
        sx_d[k] = xin;
        sr_d[k] = rin >> 1;
      end
    end
  end

  // arc height, rescale and recentre
  logic signed [32:0]   m_w;
  logic [MW-1:0]        am_q;
  logic                 mneg_q, mneg_x_q;
  logic [PW-1:0]        prod_q;
  logic [PW:0]          prod_rnd;
  logic [SCW-1:0]       sc_w;
  logic signed [SCW:0]  ssc_w;
  logic signed [TW-1:0] tot_q, half_w;
  logic signed [SW-1:0] arc_w;

  assign m_w      = $signed({2'b0, srt_q[SQN-1][30:0]}) + $signed({2'b0, ONE_Q[FRAC:0]})
                    - $signed({2'b0, r30_w});
  assign prod_rnd = {1'b0, prod_q} + (PW+1)'(HALF_Q);
  assign sc_w     = prod_rnd[PW:FRAC];
  assign ssc_w    = (mneg_x_q ^ meta_q[S_Y-1].neg) ? -$signed({1'b0, sc_w})
                                                   : $signed({1'b0, sc_w});
  assign half_w   = tot_q >>> 1;
  assign arc_w    = (half_w > SAT_HI) ? SAT_HI[SW-1:0] :
                    (half_w < SAT_LO) ? SAT_LO[SW-1:0] : half_w[SW-1:0];

  // output selection
  logic signed [SW-1:0] shaped_w;
  logic [2:0]           region_w;
  ssf_pkg::meta_t       ml_w;

  always_comb begin
    ml_w = meta_q[NST-1];
    if (ml_w.bad) begin
      shaped_w = ml_w.x;
      region_w = ssf_pkg::REGION_LINEAR;
    end else begin
      case (ml_w.cls)
        ssf_pkg::CLS_FLAT: begin
          shaped_w = ml_w.neg ? lower_q : upper_q;
          region_w = ml_w.neg ? ssf_pkg::REGION_LOWER_FLAT : ssf_pkg::REGION_UPPER_FLAT;
        end
        ssf_pkg::CLS_ARC: begin
          shaped_w = arc_w;
          region_w = ml_w.neg ? ssf_pkg::REGION_LOWER_ARC : ssf_pkg::REGION_UPPER_ARC;
        end
        default: begin
          shaped_w = ml_w.x;
          region_w = ssf_pkg::REGION_LINEAR;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= m0_w;
      ad_q      <= ad_w;
      for (int k = 1; k < NST; k++) begin
        meta_q[k] <= (k == S_R) ? mr_w : meta_q[k-1];
      end
      drem_q <= drem_d;
      dq_q   <= dq_d;
      t_q    <= tfull_w[30:0];
      t2_q   <= SQXW'(t_q) * SQXW'(t_q);
      sr_q   <= (rr_q > t2_q) ? rr_q - t2_q : '0;
      sx_q   <= sx_d;
      srt_q  <= sr_d;
      mneg_q <= m_w[32];
      am_q   <= m_w[32] ? MW'(-m_w) : MW'(m_w);
      mneg_x_q <= mneg_q;
      prod_q <= PW'(am_q) * PW'(rng_w);
      tot_q  <= TW'(sum_w) + TW'(ssc_w);
      shaped_o     <= shaped_w;
      region_o     <= region_w;
      bad_limits_o <= ml_w.bad;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/ssf_checker.sv =====
`include "assert_macros.svh"

module ssf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          sample_valid_i,
  input logic                          sample_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [ssf_pkg::SW-1:0] shaped_o,
  input logic [2:0]                    region_o,
  input logic                          bad_limits_o
);

  `SSF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(shaped_o) && $stable(region_o))
  `SSF_ASSERT(a_backpressure, out_valid_o && out_stall_i |-> sample_stall_o)
  `SSF_ASSERT(a_bad_is_linear, out_valid_o && bad_limits_o |-> region_o == ssf_pkg::REGION_LINEAR)
  `SSF_ASSERT_ALWAYS(a_no_idle_stall, !out_valid_o |-> !sample_stall_o)

endmodule

bind soft_saturation_fillet ssf_checker u_ssf_checker (.*);
